/* rtl/core/dust_sensor_reply_frame_checker_top_assert.svh */
// Assertion macros used by the checker file of the reply frame checker.
`ifndef DUST_SENSOR_REPLY_FRAME_CHECKER_TOP_ASSERT_SVH
`define DUST_SENSOR_REPLY_FRAME_CHECKER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSRFC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DSRFC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/dsrfc_pkg.sv */
package dsrfc_pkg;

    // Frame layout and fixed byte values.
    localparam logic [3:0] FRAME_LEN   = 4'd10;
    localparam logic [7:0] HEAD_BYTE   = 8'hAA;
    localparam logic [7:0] TAIL_BYTE   = 8'hAB;
    localparam logic [7:0] REPLY_QUERY = 8'hC0;
    localparam logic [7:0] REPLY_OTHER = 8'hC5;
    localparam logic [7:0] QUERY_CMD   = 8'd4;

    // Frame byte positions that carry a check.
    localparam logic [3:0] POS_HEAD  = 4'd0;
    localparam logic [3:0] POS_REPLY = 4'd1;
    localparam logic [3:0] POS_ECHO  = 4'd2;
    localparam logic [3:0] POS_SUM   = 4'd8;
    localparam logic [3:0] POS_TAIL  = 4'd9;
    localparam logic [3:0] POS_DATA0 = 4'd2;

    localparam int PAYLOAD_LEN = 6;

    // Configuration register index (paddr bit 2).
    localparam logic REG_EXPECTED_COMMAND = 1'b0;

    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_RESTART = 2'd1,
        KIND_IDLE    = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_HEADER   = 3'd1,
        ERR_REPLY    = 3'd2,
        ERR_ECHO     = 3'd3,
        ERR_CHECKSUM = 3'd4,
        ERR_TAIL     = 3'd5,
        ERR_SHORT    = 3'd6
    } err_code_t;

    // One frame report as it leaves the checker.
    typedef struct packed {
        logic                              frame_ok;
        err_code_t                         error_code;
        logic [3:0]                        bytes_seen;
        logic [PAYLOAD_LEN-1:0][7:0]       payload;
    } result_t;

endpackage

/* rtl/core/dsrfc_frame_check.sv */
module dsrfc_frame_check
    import dsrfc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_accept,
    input  logic [1:0] in_kind,
    input  logic [7:0] in_byte,
    input  logic [7:0] expected_command,
    output logic       res_valid,
    output result_t    res
);

    logic [3:0]                  pos_reg, pos_next;
    logic [7:0]                  sum_reg, sum_next;
    err_code_t                   err_reg, err_next;
    logic [PAYLOAD_LEN-1:0][7:0] pay_reg, pay_next;

    logic                        pos_wrap;
    logic [3:0]                  pos_eff;
    logic [7:0]                  sum_eff;
    err_code_t                   err_eff;
    logic [PAYLOAD_LEN-1:0][7:0] pay_eff;
    logic [7:0]                  sum_byte;
    logic [PAYLOAD_LEN-1:0][7:0] pay_byte;
    err_code_t                   chk_err;
    err_code_t                   err_byte;
    logic [3:0]                  pos_inc;
    logic                        is_query;

    // A position left at the frame length starts a fresh frame.
    assign pos_wrap = (pos_reg >= FRAME_LEN);
    assign pos_eff  = pos_wrap ? 4'd0 : pos_reg;
    assign sum_eff  = pos_wrap ? 8'd0 : sum_reg;
    assign err_eff  = pos_wrap ? ERR_NONE : err_reg;
    assign pay_eff  = pos_wrap ? '0 : pay_reg;
    assign is_query = (expected_command == QUERY_CMD);

    // Payload bytes are stored and added into the checksum.
    assign sum_byte = ((pos_eff >= POS_DATA0) && (pos_eff < POS_SUM)) ? sum_eff + in_byte
                                                                       : sum_eff;
    always_comb begin
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            pay_byte[i] = (pos_eff == POS_DATA0 + 4'(i)) ? in_byte : pay_eff[i];
        end
    end

    // Check for the byte at its position in the frame.
    always_comb begin
        chk_err = ERR_NONE;
        unique case (pos_eff)
            POS_HEAD: begin
                if (in_byte != HEAD_BYTE) chk_err = ERR_HEADER;
            end
            POS_REPLY: begin
                if (in_byte != (is_query ? REPLY_QUERY : REPLY_OTHER)) chk_err = ERR_REPLY;
            end
            POS_ECHO: begin
                if (!is_query && (in_byte != expected_command)) chk_err = ERR_ECHO;
            end
            POS_SUM: begin
                if (in_byte != sum_eff) chk_err = ERR_CHECKSUM;
            end
            POS_TAIL: begin
                if (in_byte != TAIL_BYTE) chk_err = ERR_TAIL;
            end
            default: begin
                chk_err = ERR_NONE;
            end
        endcase
    end

    // Only the first error of a frame is kept.
    assign err_byte = (err_eff != ERR_NONE) ? err_eff : chk_err;
    assign pos_inc  = pos_eff + 4'd1;

    // Frame state update and report for each accepted transaction.
    always_comb begin
        pos_next            = pos_reg;
        sum_next            = sum_reg;
        err_next            = err_reg;
        pay_next            = pay_reg;
        res_valid           = 1'b0;
        res.frame_ok        = 1'b0;
        res.error_code      = ERR_NONE;
        res.bytes_seen      = pos_reg;
        res.payload         = pay_reg;
        if (in_accept) begin
            unique case (kind_t'(in_kind))
                KIND_RESTART: begin
                    pos_next = '0;
                    sum_next = '0;
                    err_next = ERR_NONE;
                    pay_next = '0;
                end
                KIND_IDLE: begin
                    res_valid      = 1'b1;
                    res.error_code = (err_reg != ERR_NONE) ? err_reg : ERR_SHORT;
                    pos_next       = '0;
                    sum_next       = '0;
                    err_next       = ERR_NONE;
                    pay_next       = '0;
                end
                KIND_BYTE: begin
                    if (pos_inc >= FRAME_LEN) begin
                        res_valid      = 1'b1;
                        res.frame_ok   = (err_byte == ERR_NONE);
                        res.error_code = err_byte;
                        res.bytes_seen = FRAME_LEN;
                        res.payload    = pay_byte;
                        pos_next       = '0;
                        sum_next       = '0;
                        err_next       = ERR_NONE;
                        pay_next       = '0;
                    end else begin
                        pos_next = pos_inc;
                        sum_next = sum_byte;
                        err_next = err_byte;
                        pay_next = pay_byte;
                    end
                end
                default: begin
                    // Unused kind code: nothing changes.
                    pos_next = pos_reg;
                end
            endcase
        end
    end

    // Frame state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            sum_reg <= '0;
            err_reg <= ERR_NONE;
            pay_reg <= '0;
        end else begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
            err_reg <= err_next;
            pay_reg <= pay_next;
        end
    end

endmodule

/* rtl/core/dsrfc_skid.sv */
module dsrfc_skid
    import dsrfc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  result_t in_data,
    output logic    in_room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    // Room for one more report as long as the spare entry is empty.
    assign in_room   = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;
    assign pop       = main_valid_reg && out_ready;

    // Output entry is refilled from the spare entry first.
    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        priority if (skid_valid_reg) begin
            if (pop) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (in_valid) begin
            if (!main_valid_reg || pop) begin
                main_next       = in_data;
                main_valid_next = 1'b1;
            end else begin
                skid_next       = in_data;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload entries need no reset.
    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

/* rtl/core/dust_sensor_reply_frame_checker_top.sv */
// Reply frame checker: one received byte or line event per transaction.
// Throughput: one input transaction per cycle while the two-entry output stage has room.
// A report for the transaction that ends a frame is registered in the output stage before it shows on m_tvalid.
// The per-byte check is one compare and an 8-bit add between the frame state registers.
// Reset (aresetn low, synchronous) clears the frame state and the output stage,
// and sets expected_command to 4.
module dust_sensor_reply_frame_checker_top
    import dsrfc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_tuser,   // [1:0] kind
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] error_code, [6:3] bytes_seen, [14:7] data_1, [22:15] data_2,
    // [30:23] data_3, [38:31] data_4, [46:39] data_5, [54:47] data_6,
    // [70:55] pm25_tenths, [86:71] pm10_tenths, [87] zero
    output logic [87:0] m_tdata,
    output logic        m_tuser,   // [0] frame_ok
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] cmd_reg;
    logic       in_accept;
    logic       res_valid;
    result_t    res;
    result_t    out_res;

    // Configuration register.
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg <= QUERY_CMD;
        end else if (psel && penable && pwrite && (paddr[2] == REG_EXPECTED_COMMAND)) begin
            cmd_reg <= pwdata[7:0];
        end
    end
    assign prdata = (paddr[2] == REG_EXPECTED_COMMAND) ? {24'd0, cmd_reg} : 32'd0;

    assign in_accept = s_tvalid && s_tready;

    dsrfc_frame_check u_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_accept        (in_accept),
        .in_kind          (s_tuser),
        .in_byte          (s_tdata),
        .expected_command (cmd_reg),
        .res_valid        (res_valid),
        .res              (res)
    );

    dsrfc_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   (res),
        .in_room   (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    // Pack the report; the PM values are little-endian byte pairs.
    assign m_tuser = out_res.frame_ok;
    assign m_tdata = {1'b0,
                      out_res.payload[3], out_res.payload[2],
                      out_res.payload[1], out_res.payload[0],
                      out_res.payload,
                      out_res.bytes_seen,
                      out_res.error_code};

endmodule

/* rtl/core/dsrfc_checker.sv */
`include "dust_sensor_reply_frame_checker_top_assert.svh"

module dsrfc_checker
    import dsrfc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata,
    input logic        m_tuser
);

    // A passed frame has no error and all ten bytes.
    `DSRFC_ASSERT_IMP(a_ok_full, m_tvalid && m_tuser, (m_tdata[2:0] == ERR_NONE) && (m_tdata[6:3] == FRAME_LEN), "frame_ok without a clean full frame")

    // A failed report always names an error and never counts past the frame.
    `DSRFC_ASSERT_IMP(a_fail_code, m_tvalid && !m_tuser, (m_tdata[2:0] != ERR_NONE) && (m_tdata[6:3] <= FRAME_LEN), "failed report without error code")

    // The PM values are the first four payload bytes.
    `DSRFC_ASSERT_IMP(a_pm_bytes, m_tvalid, (m_tdata[62:55] == m_tdata[14:7]) && (m_tdata[70:63] == m_tdata[22:15]) && (m_tdata[78:71] == m_tdata[30:23]) && (m_tdata[86:79] == m_tdata[38:31]), "PM fields disagree with payload")

    // A stalled report holds.
    `DSRFC_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled report changed")

endmodule

bind dust_sensor_reply_frame_checker_top dsrfc_checker u_checker (.*);

/* test/tb_dust_sensor_reply_frame_checker_top.sv */
module tb_dust_sensor_reply_frame_checker_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dsrfc_pkg::*;

    // Kind code that the checker must ignore.
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;
    localparam logic [2:0] CMD_ADDR     = {REG_EXPECTED_COMMAND, 2'b00};
    localparam int ITEMS_PER_PHASE      = 205;
    localparam int SETTLE_CYCLES        = 4;
    localparam int CYCLE_LIMIT          = 500000;

    // One frame report, split into its fields.
    typedef struct packed {
        logic             ok;
        logic [2:0]       code;
        logic [3:0]       seen;
        logic [5:0][7:0]  data;
        logic [15:0]      pm25;
        logic [15:0]      pm10;
    } frame_report_t;

    typedef logic [9:0][7:0] frame_bytes_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic        m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor copy of the register and the frame state.
    logic [7:0]      cfg_command = QUERY_CMD;
    logic [3:0]      frame_pos = '0;
    logic [7:0]      frame_sum = '0;
    err_code_t       frame_error = ERR_NONE;
    logic [5:0][7:0] frame_payload = '0;

    frame_report_t pending_reports[$];
    frame_report_t want_report;
    frame_report_t got_report;
    int            fault_count = 0;
    int            items_sent = 0;
    bit            tx_steady = 1'b0;
    bit            rx_steady = 1'b0;

    dust_sensor_reply_frame_checker_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Clears everything that belongs to the frame in progress.
    task automatic clear_frame_state();
        frame_pos = '0;
        frame_sum = '0;
        frame_error = ERR_NONE;
        frame_payload = '0;
    endtask

    // Builds the report for the frame state as it stands.
    function automatic frame_report_t make_report(logic ok, logic [2:0] code,
                                                  logic [3:0] seen);
        frame_report_t r;
        r.ok = ok;
        r.code = code;
        r.seen = seen;
        r.data = frame_payload;
        r.pm25 = {frame_payload[1], frame_payload[0]};
        r.pm10 = {frame_payload[3], frame_payload[2]};
        return r;
    endfunction

    // Advances the frame state by one accepted transaction and queues any report.
    task automatic predict_frame_report(input logic [1:0] kind, input logic [7:0] b);
        logic [3:0] p;
        err_code_t  found;
        found = ERR_NONE;
        case (kind)
            KIND_RESTART: clear_frame_state();
            KIND_IDLE: begin
                pending_reports.push_back(make_report(1'b0,
                    (frame_error != ERR_NONE) ? frame_error : ERR_SHORT, frame_pos));
                clear_frame_state();
            end
            KIND_BYTE: begin
                p = frame_pos;
                if (p >= FRAME_LEN) begin
                    clear_frame_state();
                    p = '0;
                end
                if (p >= POS_DATA0 && p < POS_SUM) begin
                    frame_payload[p - POS_DATA0] = b;
                    frame_sum = frame_sum + b;
                end
                case (p)
                    POS_HEAD:  if (b != HEAD_BYTE) found = ERR_HEADER;
                    POS_REPLY: begin
                        if (b != ((cfg_command == QUERY_CMD) ? REPLY_QUERY : REPLY_OTHER))
                            found = ERR_REPLY;
                    end
                    POS_ECHO: begin
                        if (cfg_command != QUERY_CMD && b != cfg_command)
                            found = ERR_ECHO;
                    end
                    POS_SUM:   if (b != frame_sum) found = ERR_CHECKSUM;
                    POS_TAIL:  if (b != TAIL_BYTE) found = ERR_TAIL;
                    default: ;
                endcase
                // Only the first error of a frame is kept.
                if (frame_error == ERR_NONE)
                    frame_error = found;
                frame_pos = p + 4'd1;
                if (frame_pos >= FRAME_LEN) begin
                    pending_reports.push_back(make_report(frame_error == ERR_NONE,
                                                          frame_error, FRAME_LEN));
                    clear_frame_state();
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
            fault_count++;
        end
    endtask

    // Predict on input transactions and check result transactions at each edge.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            predict_frame_report(s_tuser, s_tdata);
        if (aresetn && m_tvalid && m_tready) begin
            got_report.ok = m_tuser;
            got_report.code = m_tdata[2:0];
            got_report.seen = m_tdata[6:3];
            for (int i = 0; i < PAYLOAD_LEN; i++)
                got_report.data[i] = m_tdata[7 + 8 * i +: 8];
            got_report.pm25 = m_tdata[70:55];
            got_report.pm10 = m_tdata[86:71];
            if (pending_reports.size() == 0) begin
                $display("%0t ns: report expected none, got %0h", $time, got_report);
                fault_count++;
            end else begin
                want_report = pending_reports.pop_front();
                check_field("frame_ok", want_report.ok, got_report.ok);
                check_field("error_code", want_report.code, got_report.code);
                check_field("bytes_seen", want_report.seen, got_report.seen);
                for (int i = 0; i < PAYLOAD_LEN; i++)
                    check_field($sformatf("data_%0d", i + 1), want_report.data[i],
                                got_report.data[i]);
                check_field("pm25_tenths", want_report.pm25, got_report.pm25);
                check_field("pm10_tenths", want_report.pm10, got_report.pm10);
            end
        end
    end

    // Result side: a random stall before each transaction, with calm stretches.
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            if ($urandom_range(0, 15) == 0)
                rx_steady = !rx_steady;
            stall = rx_steady ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Sends one transaction; s_tvalid stays high unless a gap follows.
    task automatic send_item(input logic [1:0] kind, input logic [7:0] b);
        int gap;
        if ($urandom_range(0, 31) == 0)
            tx_steady = !tx_steady;
        gap = tx_steady ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (kind != KIND_UNKNOWN)
            items_sent++;
    endtask

    // Holds the input back until every report has come and the block has settled.
    task automatic wait_for_reports();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_transfer(input logic write_en, input logic [31:0] wdata,
                                output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write_en;
        paddr <= CMD_ADDR;
        pwdata <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Writes the command register and reads it back.
    task automatic set_expected_command(input logic [7:0] cmd);
        logic [31:0] readback;
        apb_transfer(1'b1, {24'd0, cmd}, readback);
        cfg_command = cmd;
        apb_transfer(1'b0, '0, readback);
        check_field("expected_command", {24'd0, cmd}, readback);
    endtask

    // Well-formed reply for the given command and payload.
    function automatic frame_bytes_t build_frame(input logic [7:0] cmd,
                                                 input logic [5:0][7:0] pl);
        frame_bytes_t fb;
        logic [7:0]   sum;
        if (cmd != QUERY_CMD)
            pl[0] = cmd;
        fb[POS_HEAD] = HEAD_BYTE;
        fb[POS_REPLY] = (cmd == QUERY_CMD) ? REPLY_QUERY : REPLY_OTHER;
        sum = '0;
        for (int k = 0; k < PAYLOAD_LEN; k++) begin
            fb[POS_DATA0 + k] = pl[k];
            sum = sum + pl[k];
        end
        fb[POS_SUM] = sum;
        fb[POS_TAIL] = TAIL_BYTE;
        return fb;
    endfunction

    task automatic test_register_reset();
        logic [31:0] readback;
        apb_transfer(1'b0, '0, readback);
        check_field("expected_command", {24'd0, QUERY_CMD}, readback);
    endtask

    // Query replies: clean frame with full payload, no reply, wrong type, restart.
    task automatic test_query_reply_checks();
        frame_bytes_t fb;
        fb = build_frame(QUERY_CMD, {PAYLOAD_LEN{8'hFF}});
        for (int k = 0; k < FRAME_LEN; k++)
            send_item(KIND_BYTE, fb[k]);
        send_item(KIND_IDLE, 8'h00);
        send_item(KIND_BYTE, HEAD_BYTE);
        send_item(KIND_BYTE, REPLY_OTHER);
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_UNKNOWN, 8'hFF);
        send_item(KIND_IDLE, 8'hFF);
        send_item(KIND_BYTE, HEAD_BYTE);
        send_item(KIND_RESTART, 8'h00);
        wait_for_reports();
    endtask

    // A non-query command must be echoed in byte 2.
    task automatic test_command_echo();
        set_expected_command(8'hFF);
        send_item(KIND_BYTE, HEAD_BYTE);
        send_item(KIND_BYTE, REPLY_OTHER);
        send_item(KIND_BYTE, 8'h12);
        send_item(KIND_IDLE, 8'h00);
        wait_for_reports();
    endtask

    // Mostly good frames, some corrupted, cut short, restarted, or plain noise.
    task automatic send_random_frame();
        frame_bytes_t    fb;
        logic [5:0][7:0] pl;
        int              flavour;
        int              cut;
        for (int k = 0; k < PAYLOAD_LEN; k++) begin
            case ($urandom_range(0, 7))
                0:       pl[k] = 8'h00;
                1:       pl[k] = 8'hFF;
                default: pl[k] = 8'($urandom);
            endcase
        end
        fb = build_frame(cfg_command, pl);
        flavour = $urandom_range(0, 9);
        if (flavour == 9) begin
            repeat ($urandom_range(1, 12))
                send_item(2'($urandom_range(0, 3)), 8'($urandom));
            send_item($urandom_range(0, 1) ? KIND_IDLE : KIND_RESTART, 8'($urandom));
        end else begin
            if (flavour == 5 || flavour == 6)
                repeat (flavour - 4)
                    fb[$urandom_range(0, 9)] ^= 8'($urandom_range(1, 255));
            cut = (flavour == 7 || flavour == 8) ? $urandom_range(0, 9) : FRAME_LEN;
            for (int k = 0; k < cut; k++) begin
                if ($urandom_range(0, 19) == 0)
                    send_item(KIND_UNKNOWN, 8'($urandom));
                send_item(KIND_BYTE, fb[k]);
            end
            if (flavour == 7)
                send_item(KIND_IDLE, 8'($urandom));
            else if (flavour == 8)
                send_item(KIND_RESTART, 8'($urandom));
        end
    endtask

    task automatic test_random_traffic();
        logic [7:0] settings[6];
        int         start;
        settings = '{QUERY_CMD, 8'h00, 8'hFF, 8'($urandom), QUERY_CMD,
                     8'($urandom_range(0, 255))};
        foreach (settings[i]) begin
            set_expected_command(settings[i]);
            start = items_sent;
            while (items_sent - start < ITEMS_PER_PHASE)
                send_random_frame();
            wait_for_reports();
        end
    endtask

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("[dust_sensor_reply_frame_checker_top] ERROR");
        $finish;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_register_reset();
        test_query_reply_checks();
        test_command_echo();
        test_random_traffic();
        wait_for_reports();
        if (pending_reports.size() != 0) begin
            $display("%0t ns: reports expected 0 outstanding, got %0d", $time,
                     pending_reports.size());
            fault_count++;
        end
        if (fault_count == 0)
            $display("[dust_sensor_reply_frame_checker_top] OK");
        else
            $display("[dust_sensor_reply_frame_checker_top] ERROR");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/dsrfc_pkg.sv
rtl/core/dsrfc_frame_check.sv
rtl/core/dsrfc_skid.sv
rtl/core/dust_sensor_reply_frame_checker_top.sv
rtl/core/dsrfc_checker.sv
test/tb_dust_sensor_reply_frame_checker_top.sv
